[hdl/ddo_pkg.sv]
// Package: odometry types, constants and the CORDIC arctangent table.
`default_nettype none
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [24:0] FULL_TURN    = 25'd23592960;
  localparam logic [24:0] HALF_TURN    = 25'd11796480;
  localparam logic [24:0] QUARTER_TURN = 25'd5898240;
  localparam logic [31:0] RAD2DEG_Q20  = 32'd60078979;
  localparam logic [29:0] HALF_Q30     = 30'd536870912;
  localparam logic [33:0] GAIN_Q30     = 34'd652032874;

  // ceil(2^20 / 45) and ceil(2^20 / 3)
  localparam logic [14:0] RECIP45_Q20  = 15'd23302;
  localparam logic [18:0] RECIP3_Q20   = 19'd349526;

  localparam logic [23:0] DPC_RST = 24'd196608;
  localparam logic [15:0] TW_RST  = 16'd24576;
  localparam logic [15:0] JL_RST  = 16'd1000;

  localparam int MD_AW = 66;
  localparam int MD_BW = 36;
  localparam int MD_PW = 68;
  localparam int MD_CW = 7;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 66;

  localparam int CW = 34;
  localparam int ZW = 27;

  localparam logic [21:0] ATAN_DEG [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
    22'd1, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
  };

  typedef enum logic [1:0] {
    REG_DPC = 2'd0,
    REG_TW  = 2'd1,
    REG_JL  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_e;

  typedef struct packed {
    logic              start;
    md_op_e            op;
    logic [MD_AW-1:0]  a;
    logic [MD_BW-1:0]  b;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [MD_PW-1:0]  prod;
    logic [MD_BW-1:0]  rem;
  } md_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SL, ST_SR, ST_DD, ST_HMUL, ST_HDIV, ST_HMOD, ST_H30DIV,
    ST_H30SQ, ST_DIV48, ST_HALFMOD, ST_CORD1, ST_RMUL, ST_RDIV, ST_HEAD,
    ST_CHORD, ST_COS, ST_XMUL, ST_YMUL, ST_FIN
  } state_e;

endpackage
`default_nettype wire

[hdl/ddo_muldiv.sv]
// Shared serial unit: shift-add multiplier and restoring divider on magnitudes.
`default_nettype none
module ddo_muldiv (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  ddo_pkg::md_req_t     req_i,
  output ddo_pkg::md_rsp_t     rsp_o
);
  import ddo_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  md_op_e           op_q, op_d;
  logic [MD_CW-1:0] cnt_q, cnt_d;
  logic [MD_PW-1:0] acc_q, acc_d;
  logic [MD_PW-1:0] sh_q, sh_d;
  logic [31:0]      mpl_q, mpl_d;
  logic [MD_BW-1:0] rem_q, rem_d;
  logic [MD_BW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    mpl_d  = mpl_q;
    rem_d  = rem_q;
    trial  = {rem_q, acc_q[MD_AW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      rem_d  = '0;
      if (req_i.op == MD_MUL) begin
        cnt_d = MD_CW'(MUL_STEPS);
        acc_d = '0;
        sh_d  = {32'd0, req_i.a[MD_BW-1:0]};
        mpl_d = req_i.b[31:0];
      end else begin
        cnt_d = MD_CW'(DIV_STEPS);
        acc_d = {2'b00, req_i.a};
        sh_d  = {32'd0, req_i.b};
        mpl_d = '0;
      end
    end else if (busy_q) begin
      if (op_q == MD_MUL) begin
        if (mpl_q[0]) acc_d = acc_q + sh_q;
        sh_d  = {sh_q[MD_PW-2:0], 1'b0};
        mpl_d = {1'b0, mpl_q[31:1]};
      end else begin
        if (trial >= {1'b0, sh_q[MD_BW-1:0]}) begin
          rem_d = MD_BW'(trial - {1'b0, sh_q[MD_BW-1:0]});
          acc_d = {2'b00, acc_q[MD_AW-2:0], 1'b1};
        end else begin
          rem_d = trial[MD_BW-1:0];
          acc_d = {2'b00, acc_q[MD_AW-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - MD_CW'(1);
      if (cnt_q == MD_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MD_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    mpl_q <= mpl_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

[hdl/ddo_cordic.sv]
// Iterative CORDIC: cosine and sine in Q30 of an angle in 1/65536 degree.
`default_nettype none
module ddo_cordic #(
  parameter int CordicSteps = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [24:0]                 angle_i,
  output logic                             done_o,
  output logic signed [ddo_pkg::CW-1:0]    cos_o,
  output logic signed [ddo_pkg::CW-1:0]    sin_o
);
  import ddo_pkg::*;

  localparam int IW = $clog2(CordicSteps);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [IW-1:0]        i_q, i_d;
  logic                 neg_q, neg_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d, z0, z1, at;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    i_d    = i_q;
    neg_d  = neg_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    z0     = $signed({2'b00, angle_i});
    if (z0 > $signed({2'b00, HALF_TURN})) z0 = z0 - $signed({2'b00, FULL_TURN});
    z1     = z0;
    xs     = x_q >>> i_q;
    ys     = y_q >>> i_q;
    at     = $signed({5'd0, ATAN_DEG[5'(i_q)]});
    if (start_i) begin
      busy_d = 1'b1;
      i_d    = '0;
      x_d    = $signed(GAIN_Q30);
      y_d    = '0;
      neg_d  = 1'b0;
      if (z0 > $signed({2'b00, QUARTER_TURN})) begin
        z1    = z0 - $signed({2'b00, HALF_TURN});
        neg_d = 1'b1;
      end else if (z0 < -$signed({2'b00, QUARTER_TURN})) begin
        z1    = z0 + $signed({2'b00, HALF_TURN});
        neg_d = 1'b1;
      end
      z_d = z1;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      i_d = i_q + IW'(1);
      if (i_q == IW'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;

endmodule
`default_nettype wire

[hdl/differential_drive_odometry.sv]
// Top level: odometry sequencer, pose state, configuration and output register.
//
//  channel  direction  handshake                    payload
//  in       to block   in_valid_i / in_stall_o      count_left/right, speed_left/right
//  out      from block out_valid_o / out_stall_i    pos_x, pos_y, heading_out, speed_center
//  cfg      to block   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// A moving tick takes up to 7 multiplies and 2 divides in the serial unit
// and one or two CORDIC runs.
// in_stall_o is high while a tick is in work; the output register lets the
// next transfer in while a result waits. Reset clears pose and counts and
// loads the config registers with their defaults.
`default_nettype none
module differential_drive_odometry #(
  parameter int CordicSteps = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] count_left_i,
  input  wire logic signed [31:0] count_right_i,
  input  wire logic signed [19:0] speed_left_i,
  input  wire logic signed [19:0] speed_right_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic [24:0]             heading_out_o,
  output logic signed [19:0]      speed_center_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [23:0]        cfg_data_i
);
  import ddo_pkg::*;

  state_e state_q, state_d;
  logic   run_q, run_d;

  logic [23:0] dpc_q;
  logic [15:0] tw_q, jl_q, twe;

  logic [31:0] last_l_q, last_l_d, last_r_q, last_r_d;
  logic [31:0] x_q, x_d, y_q, y_d;
  logic [24:0] head_q, head_d;

  logic [15:0] dlm_q, dlm_d, drm_q, drm_d;
  logic        dls_q, dls_d, drs_q, drs_d;
  logic [19:0] sc_q, sc_d;
  logic [33:0] sl_q, sl_d, sr_q, sr_d;
  logic [56:0] hmag_q, hmag_d;
  logic [24:0] hmod_q, hmod_d, ang_q, ang_d;
  logic [MD_PW-1:0] tmp_q, tmp_d;
  logic [29:0] r30m_q, r30m_d;
  logic        r30s_q, r30s_d;
  logic [35:0] chord_q, chord_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] ox_q, oy_q;
  logic [24:0] oh_q;
  logic [19:0] osc_q;
  logic        out_load;

  md_req_t md_req;
  md_rsp_t md_rsp;
  logic    cor_start, cor_done;
  logic [24:0] cor_angle;
  logic signed [CW-1:0] cos_w, sin_w;

  logic [31:0] ul, ur, ml, mr;
  logic [20:0] spd_sum;
  logic        moved;
  logic [34:0] dd_w, sum_w, ddm, summ;
  logic        ddneg, sumneg;
  logic [31:0] cosm, sinm;
  logic [35:0] chordm;
  logic [40:0] s41;
  logic        sgn41, negp;
  logic [MD_PW:0] s69;
  logic [38:0] dsum;
  logic [24:0] hw;
  logic [25:0] hs;
  logic [MD_AW-1:0] q_w;
  logic [24:0] hhalf;
  logic [37:0] div3_p;

  // full turn is 45 * 2^19, and 2^12 = 1 mod 45
  function automatic logic [24:0] turn_mod(input logic [56:0] v);
    logic [37:0] hi;
    logic [13:0] fold, q14, rem14;
    logic [28:0] qp;
    hi    = v[56:19];
    fold  = {2'b00, hi[11:0]} + {2'b00, hi[23:12]} + {2'b00, hi[35:24]}
          + {12'd0, hi[37:36]};
    qp    = fold * RECIP45_Q20;
    q14   = {5'd0, qp[28:20]};
    rem14 = fold - q14 * 14'd45;
    return {rem14[5:0], v[18:0]};
  endfunction

  ddo_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  ddo_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign twe        = (tw_q == 16'd0) ? 16'd1 : tw_q;

  always_comb begin
    ul      = count_left_i - last_l_q;
    ur      = count_right_i - last_r_q;
    ml      = ul[31] ? (~ul + 32'd1) : ul;
    mr      = ur[31] ? (~ur + 32'd1) : ur;
    spd_sum = {speed_left_i[19], speed_left_i} + {speed_right_i[19], speed_right_i};
    dd_w    = {sr_q[33], sr_q} - {sl_q[33], sl_q};
    sum_w   = {sr_q[33], sr_q} + {sl_q[33], sl_q};
    ddneg   = dd_w[34];
    sumneg  = sum_w[34];
    ddm     = ddneg ? (~dd_w + 35'd1) : dd_w;
    summ    = sumneg ? (~sum_w + 35'd1) : sum_w;
    cosm    = 32'(cos_w[CW-1] ? -cos_w : cos_w);
    sinm    = 32'(sin_w[CW-1] ? -sin_w : sin_w);
    chordm  = chord_q[35] ? (~chord_q + 36'd1) : chord_q;
    q_w     = md_rsp.prod[MD_AW-1:0];
    hhalf   = turn_mod({1'b0, hmag_q[56:1]});
    // square / 2^30 / 48 is square / 2^34 / 3
    div3_p  = tmp_q[52:34] * RECIP3_Q20;

    sgn41 = (state_q == ST_SL) ? dls_q : drs_q;
    s41   = sgn41 ? (~{1'b0, md_rsp.prod[39:0]} + 41'd1) : {1'b0, md_rsp.prod[39:0]};

    negp = 1'b0;
    case (state_q)
      ST_CHORD: negp = sumneg ^ r30s_q;
      ST_XMUL:  negp = chord_q[35] ^ cos_w[CW-1];
      ST_YMUL:  negp = chord_q[35] ^ sin_w[CW-1];
      default:  negp = 1'b0;
    endcase
    s69  = negp ? (~{1'b0, md_rsp.prod} + 69'd1) : {1'b0, md_rsp.prod};
    dsum = (state_q == ST_XMUL) ? ({{7{x_q[31]}}, x_q} + s69[68:30])
                                : ({{7{y_q[31]}}, y_q} + s69[68:30]);

    hw = (ddneg && hmod_q != 25'd0) ? (FULL_TURN - hmod_q) : hmod_q;
    hs = {1'b0, head_q} + {1'b0, hw};
  end

  always_comb begin
    state_d   = state_q;
    run_d     = run_q;
    last_l_d  = last_l_q;
    last_r_d  = last_r_q;
    x_d       = x_q;
    y_d       = y_q;
    head_d    = head_q;
    dlm_d     = dlm_q;
    drm_d     = drm_q;
    dls_d     = dls_q;
    drs_d     = drs_q;
    sc_d      = sc_q;
    sl_d      = sl_q;
    sr_d      = sr_q;
    hmag_d    = hmag_q;
    hmod_d    = hmod_q;
    ang_d     = ang_q;
    tmp_d     = tmp_q;
    r30m_d    = r30m_q;
    r30s_d    = r30s_q;
    chord_d   = chord_q;
    md_req    = '{start: 1'b0, op: MD_MUL, a: '0, b: '0};
    cor_start = 1'b0;
    cor_angle = head_q;
    out_load  = 1'b0;
    moved     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dls_d = ul[31];
          drs_d = ur[31];
          dlm_d = (ml <= {16'd0, jl_q}) ? ml[15:0] : 16'd0;
          drm_d = (mr <= {16'd0, jl_q}) ? mr[15:0] : 16'd0;
          sc_d  = spd_sum[20:1];
          moved = (dlm_d != 16'd0) || (drm_d != 16'd0);
          if (moved) begin
            last_l_d = count_left_i;
            last_r_d = count_right_i;
            state_d  = ST_SL;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SL: begin
        md_req = '{start: !run_q, op: MD_MUL, a: {50'd0, dlm_q}, b: {12'd0, dpc_q}};
        if (md_rsp.done) begin
          sl_d    = {s41[40], s41[40:8]};
          state_d = ST_SR;
        end
      end
      ST_SR: begin
        md_req = '{start: !run_q, op: MD_MUL, a: {50'd0, drm_q}, b: {12'd0, dpc_q}};
        if (md_rsp.done) begin
          sr_d    = {s41[40], s41[40:8]};
          state_d = ST_DD;
        end
      end
      ST_DD: begin
        if (dd_w == 35'd0) begin
          chord_d = {{2{sl_q[33]}}, sl_q};
          state_d = ST_COS;
        end else begin
          state_d = ST_HMUL;
        end
      end
      ST_HMUL: begin
        md_req = '{start: !run_q, op: MD_MUL, a: {31'd0, ddm}, b: {4'd0, RAD2DEG_Q20}};
        if (md_rsp.done) begin
          tmp_d   = md_rsp.prod;
          state_d = ST_HDIV;
        end
      end
      ST_HDIV: begin
        md_req = '{start: !run_q, op: MD_DIV, a: tmp_q[MD_AW-1:0], b: {16'd0, twe, 4'd0}};
        if (md_rsp.done) begin
          hmag_d  = q_w[56:0];
          state_d = ST_HMOD;
        end
      end
      ST_HMOD: begin
        hmod_d  = turn_mod(hmag_q);
        state_d = (hmag_q[56:17] == '0) ? ST_H30DIV : ST_HALFMOD;
      end
      ST_H30DIV: begin
        md_req = '{start: !run_q, op: MD_DIV, a: {1'b0, ddm, 30'd0}, b: {20'd0, twe}};
        if (md_rsp.done) begin
          tmp_d   = md_rsp.prod;
          state_d = ST_H30SQ;
        end
      end
      ST_H30SQ: begin
        md_req = '{start: !run_q, op: MD_MUL, a: {34'd0, tmp_q[31:0]}, b: {4'd0, tmp_q[31:0]}};
        if (md_rsp.done) begin
          tmp_d   = md_rsp.prod;
          state_d = ST_DIV48;
        end
      end
      ST_DIV48: begin
        r30m_d  = HALF_Q30 - {12'd0, div3_p[37:20]};
        r30s_d  = 1'b0;
        state_d = ST_HEAD;
      end
      ST_HALFMOD: begin
        ang_d   = (ddneg && hhalf != 25'd0) ? (FULL_TURN - hhalf) : hhalf;
        state_d = ST_CORD1;
      end
      ST_CORD1: begin
        cor_start = !run_q;
        cor_angle = ang_q;
        if (cor_done) state_d = ST_RMUL;
      end
      ST_RMUL: begin
        md_req = '{start: !run_q, op: MD_MUL, a: {50'd0, twe}, b: {4'd0, sinm}};
        if (md_rsp.done) begin
          tmp_d   = md_rsp.prod;
          state_d = ST_RDIV;
        end
      end
      ST_RDIV: begin
        md_req = '{start: !run_q, op: MD_DIV, a: tmp_q[MD_AW-1:0], b: {1'b0, ddm}};
        if (md_rsp.done) begin
          r30m_d  = (q_w > {36'd0, HALF_Q30}) ? HALF_Q30 : q_w[29:0];
          r30s_d  = sin_w[CW-1] ^ ddneg;
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        head_d  = (hs >= {1'b0, FULL_TURN}) ? 25'(hs - {1'b0, FULL_TURN}) : hs[24:0];
        state_d = ST_CHORD;
      end
      ST_CHORD: begin
        md_req = '{start: !run_q, op: MD_MUL, a: {31'd0, summ}, b: {6'd0, r30m_q}};
        if (md_rsp.done) begin
          chord_d = s69[65:30];
          state_d = ST_COS;
        end
      end
      ST_COS: begin
        cor_start = !run_q;
        cor_angle = head_q;
        if (cor_done) state_d = ST_XMUL;
      end
      ST_XMUL: begin
        md_req = '{start: !run_q, op: MD_MUL, a: {30'd0, chordm}, b: {4'd0, cosm}};
        if (md_rsp.done) begin
          if (!dsum[38] && (dsum[37:31] != '0))      x_d = 32'h7FFF_FFFF;
          else if (dsum[38] && (dsum[37:31] != '1))  x_d = 32'h8000_0000;
          else                                       x_d = dsum[31:0];
          state_d = ST_YMUL;
        end
      end
      ST_YMUL: begin
        md_req = '{start: !run_q, op: MD_MUL, a: {30'd0, chordm}, b: {4'd0, sinm}};
        if (md_rsp.done) begin
          if (!dsum[38] && (dsum[37:31] != '0))      y_d = 32'h7FFF_FFFF;
          else if (dsum[38] && (dsum[37:31] != '1))  y_d = 32'h8000_0000;
          else                                       y_d = dsum[31:0];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (md_req.start || cor_start) run_d = 1'b1;
    if (md_rsp.done || cor_done)   run_d = 1'b0;

    out_valid_d = out_valid_q;
    if (out_load)                          out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      last_l_q    <= '0;
      last_r_q    <= '0;
      x_q         <= '0;
      y_q         <= '0;
      head_q      <= '0;
      dpc_q       <= DPC_RST;
      tw_q        <= TW_RST;
      jl_q        <= JL_RST;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      last_l_q    <= last_l_d;
      last_r_q    <= last_r_d;
      x_q         <= x_d;
      y_q         <= y_d;
      head_q      <= head_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_DPC: dpc_q <= cfg_data_i;
          REG_TW:  tw_q  <= cfg_data_i[15:0];
          REG_JL:  jl_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dlm_q   <= dlm_d;
    drm_q   <= drm_d;
    dls_q   <= dls_d;
    drs_q   <= drs_d;
    sc_q    <= sc_d;
    sl_q    <= sl_d;
    sr_q    <= sr_d;
    hmag_q  <= hmag_d;
    hmod_q  <= hmod_d;
    ang_q   <= ang_d;
    tmp_q   <= tmp_d;
    r30m_q  <= r30m_d;
    r30s_q  <= r30s_d;
    chord_q <= chord_d;
    if (out_load) begin
      ox_q  <= x_q;
      oy_q  <= y_q;
      oh_q  <= head_q;
      osc_q <= sc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = ox_q;
  assign pos_y_o        = oy_q;
  assign heading_out_o  = oh_q;
  assign speed_center_o = osc_q;

endmodule
`default_nettype wire
